### rtl/core/ljpe_pkg.sv
// Shared types and constants for the Lennard-Jones pair energy pipeline.
package ljpe_pkg;

  // Divisor width (r^2 with twice the coordinate fraction bits) and quotient width
  localparam int DEN_W  = 52;
  localparam int QUOT_W = 63;

  // Quotient cap and the positive energy clip value
  localparam logic [QUOT_W-1:0] XCAP = {QUOT_W{1'b1}};
  localparam logic [31:0]       EMAX = 32'h7FFF_FFFF;

  // Configuration register reset values
  localparam logic [23:0] BOX_SIZE_RST  = 24'd1861222;
  localparam logic [23:0] EPSILON_RST   = 24'd221093;
  localparam logic [27:0] SIGMA_SIX_RST = 28'd91802956;

  // Configuration register index
  typedef enum logic [1:0] {
    REG_BOX_SIZE,
    REG_EPSILON,
    REG_SIGMA_SIX
  } cfg_reg_t;

  // Control that travels alongside each divider request
  typedef struct packed {
    logic valid;
    logic force_cap;
  } div_ctl_t;

endpackage

### rtl/core/lennard_jones_pair_energy_top.sv
// Lennard-Jones 12-6 pair energy with minimum-image wrap, fully pipelined.
//
//  channel | ports                                   | handshake
//  in      | in_pos_a_{x,y,z}, in_pos_b_{x,y,z}      | in_valid / in_ready
//  out     | out_pair_energy, out_saturated          | out_valid / out_ready
//  cfg     | psel penable pwrite paddr pwdata prdata | APB write, pready tied high
//
//  One request enters per cycle while in_ready is high; the pipeline is the
//  three 64-stage dividers (an alignment stage, then one quotient bit per stage)
//  plus wrap, square and multiply stages.
//  Reset (synchronous, rst_n low) clears all valid bits and loads register defaults.
//  A two-entry output buffer lets requests keep entering while a result waits;
//  the whole pipeline holds only when both entries are full.
module lennard_jones_pair_energy_top import ljpe_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [23:0]        in_pos_a_x,
  input  logic [23:0]        in_pos_a_y,
  input  logic [23:0]        in_pos_a_z,
  input  logic [23:0]        in_pos_b_x,
  input  logic [23:0]        in_pos_b_y,
  input  logic [23:0]        in_pos_b_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pair_energy,
  output logic               out_saturated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int SH1 = 2 * COORD_FRAC_BITS + 16;
  localparam int SH2 = 2 * COORD_FRAC_BITS;

  // Configuration registers
  logic [23:0] box_size_r;
  logic [23:0] epsilon_r;
  logic [27:0] sigma_six_r;
  cfg_reg_t    reg_sel;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_size_r  <= BOX_SIZE_RST;
      epsilon_r   <= EPSILON_RST;
      sigma_six_r <= SIGMA_SIX_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_BOX_SIZE:  box_size_r  <= pwdata[23:0];
        REG_EPSILON:   epsilon_r   <= pwdata[23:0];
        REG_SIGMA_SIX: sigma_six_r <= pwdata[27:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BOX_SIZE:  prdata = {8'd0, box_size_r};
      REG_EPSILON:   prdata = {8'd0, epsilon_r};
      REG_SIGMA_SIX: prdata = {4'd0, sigma_six_r};
      default:       prdata = '0;
    endcase
  end

  // Global advance: hold everything only when the output buffer is full
  logic en;
  logic skid_valid_r;

  assign en       = ~skid_valid_r;
  assign in_ready = en;

  // Stage 1: per-axis difference and wrap decision
  logic [23:0]        pos_a [3];
  logic [23:0]        pos_b [3];
  logic signed [24:0] d_nxt [3];
  logic signed [26:0] d2    [3];
  logic signed [26:0] bxs;
  logic               lt_nxt [3];
  logic               gt_nxt [3];

  logic               s1_vld_r;
  logic signed [24:0] s1_d_r  [3];
  logic               s1_lt_r [3];
  logic               s1_gt_r [3];

  assign pos_a[0] = in_pos_a_x;
  assign pos_a[1] = in_pos_a_y;
  assign pos_a[2] = in_pos_a_z;
  assign pos_b[0] = in_pos_b_x;
  assign pos_b[1] = in_pos_b_y;
  assign pos_b[2] = in_pos_b_z;
  assign bxs      = $signed({3'd0, box_size_r});

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      d_nxt[ax]  = $signed({1'b0, pos_a[ax]}) - $signed({1'b0, pos_b[ax]});
      d2[ax]     = {d_nxt[ax][24], d_nxt[ax], 1'b0};
      lt_nxt[ax] = d2[ax] < -bxs;
      gt_nxt[ax] = d2[ax] > bxs;
    end
  end

  // Stage 2: wrapped difference
  logic               s2_vld_r;
  logic signed [25:0] s2_w_r [3];
  // Stage 3: magnitude
  logic               s3_vld_r;
  logic [24:0]        s3_ad_r [3];
  // Stage 4: squares
  logic               s4_vld_r;
  logic [49:0]        s4_sq_r [3];
  // Stage 5: r^2
  logic               s5_vld_r;
  logic [DEN_W-1:0]   s5_r2_r;

  logic signed [25:0] w_nxt [3];
  logic signed [25:0] bxw;

  assign bxw = $signed({2'd0, box_size_r});

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      priority if (s1_lt_r[ax]) w_nxt[ax] = 26'(s1_d_r[ax]) + bxw;
      else if (s1_gt_r[ax])     w_nxt[ax] = 26'(s1_d_r[ax]) - bxw;
      else                      w_nxt[ax] = 26'(s1_d_r[ax]);
    end
  end

  // Advance front-end valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  // Advance front-end payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int ax = 0; ax < 3; ax++) begin
        s1_d_r[ax]  <= d_nxt[ax];
        s1_lt_r[ax] <= lt_nxt[ax];
        s1_gt_r[ax] <= gt_nxt[ax];
        s2_w_r[ax]  <= w_nxt[ax];
        s3_ad_r[ax] <= s2_w_r[ax][25] ? 25'(-s2_w_r[ax]) : 25'(s2_w_r[ax]);
        s4_sq_r[ax] <= s3_ad_r[ax] * s3_ad_r[ax];
      end
      s5_r2_r <= DEN_W'(s4_sq_r[0]) + DEN_W'(s4_sq_r[1]) + DEN_W'(s4_sq_r[2]);
    end
  end

  // Three chained divisions by r^2 give sigma6 / r^6
  div_ctl_t            d0_ctl, d1_ctl, d2_ctl, d3_ctl;
  logic [QUOT_W-1:0]   q1, q2, q3;
  logic [DEN_W-1:0]    den1, den2, den3;

  assign d0_ctl.valid     = s5_vld_r;
  assign d0_ctl.force_cap = 1'b0;

  ljpe_div #(.N_W(28), .SHIFT(SH1)) u_div1 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_ctl(d0_ctl), .in_num(sigma_six_r), .in_den(s5_r2_r),
    .out_ctl(d1_ctl), .out_quot(q1), .out_den(den1)
  );

  ljpe_div #(.N_W(QUOT_W), .SHIFT(SH2)) u_div2 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_ctl(d1_ctl), .in_num(q1), .in_den(den1),
    .out_ctl(d2_ctl), .out_quot(q2), .out_den(den2)
  );

  ljpe_div #(.N_W(QUOT_W), .SHIFT(SH2)) u_div3 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_ctl(d2_ctl), .in_num(q2), .in_den(den2),
    .out_ctl(d3_ctl), .out_quot(q3), .out_den(den3)
  );

  // X0: split x into sign and |x - 1|
  logic              x0_vld_r, x0_neg_r, x0_zero_r;
  logic [QUOT_W-1:0] x0_x_r, x0_mag_r;
  logic              neg_nxt;

  assign neg_nxt = (q3[QUOT_W-1:32] == '0);

  // M1..M6: P = x * |x - 1|, then epsilon * P
  logic        m1_vld_r, m1_neg_r, m1_zero_r;
  logic [63:0] m1_p00_r, m1_p01_r, m1_p10_r;
  logic [61:0] m1_p11_r;
  logic        m2_vld_r, m2_neg_r, m2_zero_r;
  logic [63:0] m2_p00_r, m2_mid_r;
  logic [61:0] m2_p11_r;
  logic        m3_vld_r, m3_neg_r, m3_zero_r;
  logic [125:0] m3_p_r;
  logic        m4_vld_r, m4_neg_r, m4_zero_r;
  logic [55:0] m4_e0_r, m4_e1_r, m4_e2_r;
  logic [53:0] m4_e3_r;
  logic        m5_vld_r, m5_neg_r, m5_zero_r;
  logic [88:0] m5_lo_r;
  logic [86:0] m5_hi_r;
  logic        m6_vld_r, m6_neg_r, m6_zero_r;
  logic [149:0] m6_f_r;

  // Advance back-end valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x0_vld_r <= 1'b0;
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
      m4_vld_r <= 1'b0;
      m5_vld_r <= 1'b0;
      m6_vld_r <= 1'b0;
    end else if (en) begin
      x0_vld_r <= d3_ctl.valid;
      m1_vld_r <= x0_vld_r;
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
      m4_vld_r <= m3_vld_r;
      m5_vld_r <= m4_vld_r;
      m6_vld_r <= m5_vld_r;
    end
  end

  // Advance back-end payload
  always_ff @(posedge clk) begin
    if (en) begin
      x0_x_r    <= q3;
      x0_neg_r  <= neg_nxt;
      x0_zero_r <= (den3 == '0);
      x0_mag_r  <= neg_nxt ? (QUOT_W'(64'h1_0000_0000) - q3)
                           : (q3 - QUOT_W'(64'h1_0000_0000));

      m1_p00_r  <= x0_x_r[31:0] * x0_mag_r[31:0];
      m1_p01_r  <= {32'd0, x0_x_r[31:0]} * {33'd0, x0_mag_r[QUOT_W-1:32]};
      m1_p10_r  <= {33'd0, x0_x_r[QUOT_W-1:32]} * {32'd0, x0_mag_r[31:0]};
      m1_p11_r  <= x0_x_r[QUOT_W-1:32] * x0_mag_r[QUOT_W-1:32];
      m1_neg_r  <= x0_neg_r;
      m1_zero_r <= x0_zero_r;

      m2_p00_r  <= m1_p00_r;
      m2_p11_r  <= m1_p11_r;
      m2_mid_r  <= m1_p01_r + m1_p10_r;
      m2_neg_r  <= m1_neg_r;
      m2_zero_r <= m1_zero_r;

      m3_p_r    <= {m2_p11_r, m2_p00_r} + 126'({m2_mid_r, 32'd0});
      m3_neg_r  <= m2_neg_r;
      m3_zero_r <= m2_zero_r;

      m4_e0_r   <= epsilon_r * m3_p_r[31:0];
      m4_e1_r   <= epsilon_r * m3_p_r[63:32];
      m4_e2_r   <= epsilon_r * m3_p_r[95:64];
      m4_e3_r   <= epsilon_r * m3_p_r[125:96];
      m4_neg_r  <= m3_neg_r;
      m4_zero_r <= m3_zero_r;

      m5_lo_r   <= 89'(m4_e0_r) + 89'({m4_e1_r, 32'd0});
      m5_hi_r   <= 87'(m4_e2_r) + 87'({m4_e3_r, 32'd0});
      m5_neg_r  <= m4_neg_r;
      m5_zero_r <= m4_zero_r;

      m6_f_r    <= 150'(m5_lo_r) + 150'({m5_hi_r, 64'd0});
      m6_neg_r  <= m5_neg_r;
      m6_zero_r <= m5_zero_r;
    end
  end

  // Format: scale by 2^-66, clip positive overflow and zero distance, apply sign
  logic        ovf;
  logic        push;
  logic [30:0] mag_val;
  logic [31:0] energy_nxt;
  logic        sat_nxt;

  assign ovf     = ~m6_neg_r & (|m6_f_r[149:97]);
  assign mag_val = m6_f_r[96:66];
  assign sat_nxt = m6_zero_r | ovf;
  assign push    = m6_vld_r & en;

  always_comb begin
    priority if (sat_nxt) energy_nxt = EMAX;
    else if (m6_neg_r)    energy_nxt = 32'd0 - {1'b0, mag_val};
    else                  energy_nxt = {1'b0, mag_val};
  end

  // Output buffer: head register plus one skid entry
  logic        out_valid_r;
  logic [31:0] out_energy_r, skid_energy_r;
  logic        out_sat_r, skid_sat_r;
  logic        pop;

  assign pop = out_valid_r & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || pop) begin
        out_valid_r <= skid_valid_r | push;
      end
      if (skid_valid_r && pop) begin
        skid_valid_r <= 1'b0;
      end else if (push && out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_energy_r <= skid_energy_r;
        out_sat_r    <= skid_sat_r;
      end else begin
        out_energy_r <= energy_nxt;
        out_sat_r    <= sat_nxt;
      end
    end
    if (push && out_valid_r && !pop) begin
      skid_energy_r <= energy_nxt;
      skid_sat_r    <= sat_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pair_energy = $signed(out_energy_r);
  assign out_saturated   = out_sat_r;

  // The skid entry is only ever filled behind a full head
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty head");

  // Draining the head with a waiting skid entry keeps a result on the port
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && skid_valid_r) |=> out_valid_r)
    else $error("skid entry lost on drain");

  // A clipped result always carries the positive limit
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> (out_energy_r == EMAX))
    else $error("saturated result without clip value");

  // Negative energies never clip
  a_neg_unsat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_energy_r[31]) |-> !out_saturated)
    else $error("negative energy flagged as saturated");

endmodule

### rtl/core/ljpe_div.sv
// Pipelined restoring divider: min(floor(num * 2^SHIFT / den), XCAP), one bit per stage.
module ljpe_div import ljpe_pkg::*; #(
  parameter int N_W   = 28,
  parameter int SHIFT = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  div_ctl_t          in_ctl,
  input  logic [N_W-1:0]    in_num,
  input  logic [DEN_W-1:0]  in_den,
  output div_ctl_t          out_ctl,
  output logic [QUOT_W-1:0] out_quot,
  output logic [DEN_W-1:0]  out_den
);

  localparam int RAW_W = N_W + SHIFT;
  localparam int NUM_W = (RAW_W > QUOT_W + 1) ? RAW_W : QUOT_W + 1;
  localparam int HI_W  = NUM_W - QUOT_W;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic [NUM_W-1:0]  num;
  logic [HI_W-1:0]   hi;
  logic              hi_ge;

  logic              vld_r [QUOT_W+1];
  logic              sat_r [QUOT_W+1];
  logic [DEN_W-1:0]  rem_r [QUOT_W+1];
  logic [QUOT_W-1:0] lq_r  [QUOT_W+1];
  logic [DEN_W-1:0]  den_r [QUOT_W+1];

  logic [DEN_W:0]    trial [QUOT_W];
  logic [DEN_W:0]    diff  [QUOT_W];
  logic              take  [QUOT_W];
  logic [DEN_W-1:0]  rem_nxt [QUOT_W];
  logic [QUOT_W-1:0] lq_nxt  [QUOT_W];

  // Align the numerator; bits above the quotient decide the cap up front
  assign num   = NUM_W'(in_num) << SHIFT;
  assign hi    = num[NUM_W-1:QUOT_W];
  assign hi_ge = CMP_W'(hi) >= CMP_W'(in_den);

  // One trial subtract per stage
  always_comb begin
    for (int k = 0; k < QUOT_W; k++) begin
      trial[k]   = {rem_r[k], lq_r[k][QUOT_W-1]};
      diff[k]    = trial[k] - {1'b0, den_r[k]};
      take[k]    = ~diff[k][DEN_W];
      rem_nxt[k] = take[k] ? diff[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
      lq_nxt[k]  = {lq_r[k][QUOT_W-2:0], take[k]};
    end
  end

  // Advance valid bits on enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QUOT_W; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_ctl.valid;
      for (int k = 0; k < QUOT_W; k++) vld_r[k+1] <= vld_r[k];
    end
  end

  // Advance payload on enable
  always_ff @(posedge clk) begin
    if (en) begin
      sat_r[0] <= in_ctl.force_cap | hi_ge;
      rem_r[0] <= hi_ge ? '0 : DEN_W'(hi);
      lq_r[0]  <= num[QUOT_W-1:0];
      den_r[0] <= in_den;
      for (int k = 0; k < QUOT_W; k++) begin
        sat_r[k+1] <= sat_r[k];
        rem_r[k+1] <= rem_nxt[k];
        lq_r[k+1]  <= lq_nxt[k];
        den_r[k+1] <= den_r[k];
      end
    end
  end

  // Apply the cap at the tail
  assign out_ctl.valid     = vld_r[QUOT_W];
  assign out_ctl.force_cap = sat_r[QUOT_W] | (lq_r[QUOT_W] == XCAP);
  assign out_quot          = out_ctl.force_cap ? XCAP : lq_r[QUOT_W];
  assign out_den           = den_r[QUOT_W];

endmodule

### test/ljpe_energy_checker.sv
// Checker for the Lennard-Jones pair energy block: predicts energies and compares results.
module ljpe_energy_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [23:0]        in_pos_a_x,
  input  logic [23:0]        in_pos_a_y,
  input  logic [23:0]        in_pos_a_z,
  input  logic [23:0]        in_pos_b_x,
  input  logic [23:0]        in_pos_b_y,
  input  logic [23:0]        in_pos_b_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_pair_energy,
  input  logic               out_saturated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 energies_pending
);
  import ljpe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam logic [63:0] QCAP = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [31:0] energy;
    logic        sat;
  } energy_t;

  logic [23:0] box_q;
  logic [23:0] eps_q;
  logic [27:0] s6_q;
  energy_t     energy_q[$];

  // Wrap one axis difference once by the box edge.
  function automatic longint wrap_delta(logic [23:0] a, logic [23:0] b);
    longint d;
    longint bx;
    d  = longint'(a) - longint'(b);
    bx = longint'(box_q);
    if (2 * d < -bx) d += bx;
    else if (2 * d > bx) d -= bx;
    return d;
  endfunction

  // floor(n * 2^sh / den), capped.
  function automatic logic [63:0] scaled_quot(logic [63:0] n, int sh, logic [63:0] den);
    logic [127:0] q;
    q = ({64'd0, n} << sh) / {64'd0, den};
    return (q >= {64'd0, QCAP}) ? QCAP : q[63:0];
  endfunction

  function automatic energy_t pair_energy(logic [23:0] ax, logic [23:0] ay,
                                          logic [23:0] az, logic [23:0] bx,
                                          logic [23:0] by, logic [23:0] bz);
    energy_t      e;
    longint       dx, dy, dz;
    logic [63:0]  r2, x, mag;
    logic [127:0] p;
    logic [159:0] f;
    logic         neg;
    logic [30:0]  v;
    dx = wrap_delta(ax, bx);
    dy = wrap_delta(ay, by);
    dz = wrap_delta(az, bz);
    r2 = dx * dx + dy * dy + dz * dz;
    if (r2 == 0) begin
      e.energy = EMAX;
      e.sat    = 1'b1;
      return e;
    end
    x = scaled_quot({36'd0, s6_q}, 2 * FRAC + 16, r2);
    if (x != QCAP) x = scaled_quot(x, 2 * FRAC, r2);
    if (x != QCAP) x = scaled_quot(x, 2 * FRAC, r2);
    neg = (x < 64'h1_0000_0000);
    mag = neg ? 64'h1_0000_0000 - x : x - 64'h1_0000_0000;
    p = {64'd0, x} * {64'd0, mag};
    f = {32'd0, p} * {136'd0, eps_q};
    if (!neg && f[159:97] != 0) begin
      e.energy = EMAX;
      e.sat    = 1'b1;
      return e;
    end
    v = f[96:66];
    e.energy = neg ? 32'd0 - {1'b0, v} : {1'b0, v};
    e.sat    = 1'b0;
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign energies_pending = energy_q.size();

  always @(posedge clk) begin
    energy_t want;
    if (!rst_n) begin
      box_q <= BOX_SIZE_RST;
      eps_q <= EPSILON_RST;
      s6_q  <= SIGMA_SIX_RST;
      energy_q.delete();
    end else begin
      // predict each accepted request with the current registers
      if (in_valid && in_ready)
        energy_q.push_back(pair_energy(in_pos_a_x, in_pos_a_y, in_pos_a_z,
                                       in_pos_b_x, in_pos_b_y, in_pos_b_z));
      // compare each accepted result
      if (out_valid && out_ready) begin
        if (energy_q.size() == 0) begin
          report_mismatch("unexpected result", out_pair_energy, 32'd0);
        end else begin
          want = energy_q.pop_front();
          if (out_pair_energy !== want.energy)
            report_mismatch("pair_energy", out_pair_energy, want.energy);
          if (out_saturated !== want.sat)
            report_mismatch("saturated", {31'd0, out_saturated}, {31'd0, want.sat});
        end
      end
      // track register writes
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          REG_BOX_SIZE:  box_q <= pwdata[23:0];
          REG_EPSILON:   eps_q <= pwdata[23:0];
          REG_SIGMA_SIX: s6_q  <= pwdata[27:0];
          default: ;
        endcase
      end
    end
  end

  initial fail_count = 0;
endmodule

### test/tb_lennard_jones_pair_energy_top.sv
// Testbench top for the Lennard-Jones pair energy block: stimulus and verdict.
module tb_lennard_jones_pair_energy_top;
  import ljpe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 205;
  localparam longint CYCLE_LIMIT = 400000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [23:0]        in_pos_a_x, in_pos_a_y, in_pos_a_z;
  logic [23:0]        in_pos_b_x, in_pos_b_y, in_pos_b_z;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_pair_energy;
  logic               out_saturated;
  logic               psel, penable, pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 fail_count;
  int                 energies_pending;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  longint             cycle_count;

  lennard_jones_pair_energy_top dut (.*);

  ljpe_energy_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at random.
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // Abort on a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lennard_jones_pair_energy_top verification failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Present one request, idling first, and hold it until accepted.
  task automatic send_pair(logic [23:0] ax, logic [23:0] ay, logic [23:0] az,
                           logic [23:0] bx, logic [23:0] by, logic [23:0] bz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pos_a_x <= ax;
    in_pos_a_y <= ay;
    in_pos_a_z <= az;
    in_pos_b_x <= bx;
    in_pos_b_y <= by;
    in_pos_b_z <= bz;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every result is back, then let the pipe drain.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (energies_pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(5))
      0:       return 24'hFFFFFF;
      1:       return 24'd0;
      default: return 24'($urandom);
    endcase
  endfunction

  // Random pairs, mostly at physically interesting separations.
  task automatic random_pairs(int count);
    logic [23:0] ax, ay, az;
    for (int i = 0; i < count; i++) begin
      ax = rand_coord();
      ay = rand_coord();
      az = rand_coord();
      if ($urandom_range(3) != 0)
        send_pair(ax, ay, az,
                  ax + 24'($urandom_range(20'hFFFFF)) - 24'h80000,
                  ay + 24'($urandom_range(20'h7FFFF)) - 24'h40000,
                  az + 24'($urandom_range(20'h3FFFF)) - 24'h20000);
      else
        send_pair(ax, ay, az, rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  initial begin
    cycle_count   = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    out_ready     = 1'b0;
    in_pos_a_x    = '0;
    in_pos_a_y    = '0;
    in_pos_a_z    = '0;
    in_pos_b_x    = '0;
    in_pos_b_y    = '0;
    in_pos_b_z    = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 18;
    recv_idle_pct = 64;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero distance, extremes, near contact, wrap on both sides
    send_pair(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    send_pair(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_pair(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0, 24'd0);
    send_pair(24'd0, 24'd0, 24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_pair(24'd0, 24'd0, 24'd0, 24'd1, 24'd0, 24'd0);
    send_pair(24'h40000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    send_pair(24'h60000, 24'h10000, 24'd0, 24'd0, 24'd0, 24'd0);
    send_pair(24'd0, 24'd0, 24'd0, 24'h1C0000, 24'd0, 24'd0);
    send_pair(24'h1C0000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    send_pair(24'h555555, 24'hAAAAAA, 24'h123456, 24'hAAAAAA, 24'h555555, 24'h654321);
    drain_results();

    // zero epsilon and sigma, tiny box
    write_reg(REG_EPSILON, 32'd0);
    write_reg(REG_BOX_SIZE, 32'd0);
    send_pair(24'h40000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    send_pair(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    drain_results();
    write_reg(REG_EPSILON, 32'hFFFFFF);
    write_reg(REG_SIGMA_SIX, 32'd0);
    send_pair(24'h40000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    drain_results();
    write_reg(REG_SIGMA_SIX, 32'hFFFFFFF);
    write_reg(REG_BOX_SIZE, 32'd1);
    send_pair(24'h40000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    send_pair(24'h100, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    random_pairs(300);
    drain_results();

    // widest box, reset-like chemistry
    write_reg(REG_BOX_SIZE, 32'hFFFFFF);
    write_reg(REG_EPSILON, 32'd221093);
    write_reg(REG_SIGMA_SIX, 32'd91802956);
    random_pairs(400);
    drain_results();

    // swap idling sides with random registers
    send_idle_pct = 64;
    recv_idle_pct = 18;
    write_reg(REG_BOX_SIZE, 32'($urandom));
    write_reg(REG_EPSILON, 32'($urandom));
    write_reg(REG_SIGMA_SIX, 32'($urandom));
    random_pairs(450);
    drain_results();

    // full rate, defaults again
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_BOX_SIZE, 32'd1861222);
    write_reg(REG_EPSILON, 32'd221093);
    write_reg(REG_SIGMA_SIX, 32'd91802956);
    random_pairs(600);
    drain_results();

    if (fail_count == 0)
      $display("lennard_jones_pair_energy_top verification clean");
    else
      $display("lennard_jones_pair_energy_top verification failed");
    $finish;
  end
endmodule

### filelist.f
rtl/core/ljpe_pkg.sv
rtl/core/ljpe_div.sv
rtl/core/lennard_jones_pair_energy_top.sv
test/ljpe_energy_checker.sv
test/tb_lennard_jones_pair_energy_top.sv
